@@ design/rme_pkg.sv @@
// shared types, constants and arithmetic helpers for the rotation matrix to euler block
package rme_pkg;

    // pipeline sizing
    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS    = 16;
    localparam int SQ_STG_W      = $clog2(SQRT_STEPS);
    localparam int STG_W         = 5;
    localparam int SIDE_DEPTH    = SQRT_STEPS + CORDIC_STAGES + 3;
    localparam int LATENCY       = 5 + SQRT_STEPS + 2 * CORDIC_STAGES;

    // datapath widths
    localparam int SQ_W  = 32;
    localparam int RES_W = 33;
    localparam int CX_W  = 34;
    localparam int CZ_W  = 35;
    localparam int PRE_W = 18;
    localparam int ANG_W = 19;

    localparam logic signed [CZ_W-1:0]  PI_Q30         = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANGLE_MAX_PI   = 19'sd25736;
    localparam logic signed [ANG_W-1:0] ANGLE_MAX_HALF = 19'sd12868;
    localparam logic [15:0]             THR_RESET      = 16'd1;

    // partial square root state
    typedef struct packed {
        logic [SQ_W-1:0]  rem;
        logic [RES_W-1:0] root;
    } t_sqrt;

    // vectoring cordic state
    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
        logic                   zero;
    } t_cordic;

    // matrix elements carried alongside the pitch path
    typedef struct packed {
        logic signed [15:0] xx;
        logic signed [15:0] yx;
        logic signed [15:0] zy;
        logic signed [15:0] zz;
        logic signed [15:0] yz;
        logic signed [15:0] xz;
        logic               lock;
    } t_side;

    // pitch and lock carried alongside roll and yaw
    typedef struct packed {
        logic signed [14:0] pitch;
        logic               lock;
    } t_pl;

    // arctangent table in q30, truncated
    function automatic logic signed [CZ_W-1:0] atan_q30(input logic [STG_W-1:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            5'd0:    v = 35'sd843314856;
            5'd1:    v = 35'sd497837829;
            5'd2:    v = 35'sd263043836;
            5'd3:    v = 35'sd133525158;
            5'd4:    v = 35'sd67021686;
            5'd5:    v = 35'sd33543515;
            5'd6:    v = 35'sd16775850;
            5'd7:    v = 35'sd8388437;
            5'd8:    v = 35'sd4194282;
            5'd9:    v = 35'sd2097149;
            5'd10:   v = 35'sd1048575;
            5'd11:   v = 35'sd524287;
            5'd12:   v = 35'sd262143;
            5'd13:   v = 35'sd131071;
            5'd14:   v = 35'sd65535;
            5'd15:   v = 35'sd32767;
            5'd16:   v = 35'sd16383;
            5'd17:   v = 35'sd8191;
            5'd18:   v = 35'sd4095;
            5'd19:   v = 35'sd2047;
            5'd20:   v = 35'sd1023;
            5'd21:   v = 35'sd511;
            5'd22:   v = 35'sd255;
            5'd23:   v = 35'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    // quadrant fold and scaling ahead of the cordic
    function automatic t_cordic cordic_pre(input logic signed [PRE_W-1:0] y,
                                           input logic signed [PRE_W-1:0] x);
        t_cordic                 c;
        logic signed [PRE_W-1:0] xa;
        logic signed [PRE_W-1:0] ya;
        c.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            c.z = (y >= 0) ? PI_Q30 : -PI_Q30;
            xa  = -x;
            ya  = -y;
        end else begin
            c.z = '0;
            xa  = x;
            ya  = y;
        end
        c.x = CX_W'(xa) <<< 14;
        c.y = CX_W'(ya) <<< 14;
        return c;
    endfunction

    // q30 angle to q2.13, round half away from zero
    function automatic logic signed [ANG_W-1:0] cordic_post(input t_cordic c);
        logic [CZ_W-1:0] ax;
        logic [CZ_W-1:0] rnd;
        logic [17:0]     mag;
        logic signed [ANG_W-1:0] q;
        ax  = (c.z < 0) ? CZ_W'(-c.z) : CZ_W'(c.z);
        rnd = ax + CZ_W'(65536);
        mag = rnd[CZ_W-1:17];
        q   = $signed({1'b0, mag});
        if (c.zero) begin
            return '0;
        end
        return (c.z < 0) ? -q : q;
    endfunction

    // symmetric clamp
    function automatic logic signed [ANG_W-1:0] sat(input logic signed [ANG_W-1:0] v,
                                                    input logic signed [ANG_W-1:0] lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage

@@ design/rme_sqrt_cell.sv @@
// one digit step of the integer square root chain
module rme_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rme_pkg::SQ_STG_W-1:0]  i_stage,
    input  rme_pkg::t_sqrt                i_data,
    output rme_pkg::t_sqrt                o_data
);

    logic [rme_pkg::SQ_STG_W:0]   w_sh;
    logic [rme_pkg::RES_W-1:0]    w_bit;
    logic [rme_pkg::RES_W-1:0]    w_sum;
    rme_pkg::t_sqrt               n_data;
    rme_pkg::t_sqrt               r_data;

    // trial bit for this digit
    assign w_sh  = {rme_pkg::SQ_STG_W'(rme_pkg::SQRT_STEPS - 1) - i_stage, 1'b0};
    assign w_bit = rme_pkg::RES_W'(1) << w_sh;
    assign w_sum = i_data.root + w_bit;

    // compare and subtract
    always_comb begin
        if ({1'b0, i_data.rem} >= w_sum) begin
            n_data.rem  = i_data.rem - w_sum[rme_pkg::SQ_W-1:0];
            n_data.root = (i_data.root >> 1) + w_bit;
        end else begin
            n_data.rem  = i_data.rem;
            n_data.root = i_data.root >> 1;
        end
    end

    // hand to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ design/rme_cordic_cell.sv @@
// one micro-rotation of the vectoring cordic chain
module rme_cordic_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rme_pkg::STG_W-1:0]   i_stage,
    input  rme_pkg::t_cordic            i_data,
    output rme_pkg::t_cordic            o_data
);

    logic signed [rme_pkg::CX_W-1:0] w_dx;
    logic signed [rme_pkg::CX_W-1:0] w_dy;
    logic signed [rme_pkg::CZ_W-1:0] w_atan;
    rme_pkg::t_cordic                n_data;
    rme_pkg::t_cordic                r_data;

    assign w_dx   = i_data.y >>> i_stage;
    assign w_dy   = i_data.x >>> i_stage;
    assign w_atan = rme_pkg::atan_q30(i_stage);

    // rotate toward the x axis
    always_comb begin
        n_data.zero = i_data.zero;
        if (i_data.y >= 0) begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + w_atan;
        end else begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - w_atan;
        end
    end

    // hand to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ design/rotation_matrix_to_euler.sv @@
// zyx euler angles from a rotation matrix, fully pipelined cell chains
//
//  channel  | direction | handshake             | payload
//  config   | in        | i_cfg_wr_en           | i_cfg_wr_data (gimbal threshold)
//  matrix   | in        | i_valid / o_ready     | i_rot_xx .. i_rot_xz
//  angles   | out       | o_valid / i_ready     | o_roll_angle, o_pitch_angle,
//           |           |                       | o_yaw_angle, o_gimbal_lock
//
// one matrix per cycle while the output is not stalled; the pipeline holds a square root chain (16 cells), pitch
// cordic chain (16 cells), roll and yaw cordic chains (16 cells) plus five registers.
// synchronous active-low reset clears valids and sets the threshold to 1.
// a stalled output freezes the whole pipeline; o_ready follows the output register.
module rotation_matrix_to_euler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_rot_xx,
    input  logic signed [15:0] i_rot_yx,
    input  logic signed [15:0] i_rot_zx,
    input  logic signed [15:0] i_rot_zy,
    input  logic signed [15:0] i_rot_zz,
    input  logic signed [15:0] i_rot_yz,
    input  logic signed [15:0] i_rot_xz,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle,
    output logic               o_gimbal_lock
);

    localparam int CS  = rme_pkg::CORDIC_STAGES;
    localparam int SQS = rme_pkg::SQRT_STEPS;
    localparam int SD  = rme_pkg::SIDE_DEPTH;
    localparam int LAT = rme_pkg::LATENCY;

    logic                    w_en;
    logic                    w_acc;
    logic [15:0]             r_thr;
    logic [LAT-1:0]          r_vld;
    logic [rme_pkg::SQ_W-1:0] r_sq;
    rme_pkg::t_side          r_side [0:SD-1];
    rme_pkg::t_side          w_side_in;
    rme_pkg::t_side          w_side_q;
    logic [16:0]             w_asum;
    logic signed [31:0]      w_sq_xx;
    logic signed [31:0]      w_sq_yx;
    rme_pkg::t_sqrt          w_sq [0:SQS];
    logic signed [15:0]      w_zx_d;
    logic signed [15:0]      r_zx [0:SQS];
    rme_pkg::t_cordic        r_pc;
    rme_pkg::t_cordic        w_pc [0:CS];
    logic signed [14:0]      r_pitch;
    rme_pkg::t_cordic        r_rc;
    rme_pkg::t_cordic        r_yc;
    rme_pkg::t_cordic        n_yc;
    rme_pkg::t_cordic        w_rc [0:CS];
    rme_pkg::t_cordic        w_yc [0:CS];
    rme_pkg::t_pl            r_pl [0:CS];
    logic signed [15:0]      r_roll;
    logic signed [14:0]      r_pitch_o;
    logic signed [15:0]      r_yaw;
    logic                    r_lock;
    logic signed [rme_pkg::ANG_W-1:0] w_roll_s;
    logic signed [rme_pkg::ANG_W-1:0] w_yaw_s;
    logic signed [rme_pkg::ANG_W-1:0] w_pitch_s;

    // global advance
    assign w_en    = !r_vld[LAT-1] || i_ready;
    assign w_acc   = i_valid && w_en;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rme_pkg::THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    // input stage: squares and lock test
    assign w_sq_xx = i_rot_xx * i_rot_xx;
    assign w_sq_yx = i_rot_yx * i_rot_yx;
    assign w_asum  = (i_rot_zy < 0 ? 17'(-17'(i_rot_zy)) : 17'(i_rot_zy))
                   + (i_rot_zz < 0 ? 17'(-17'(i_rot_zz)) : 17'(i_rot_zz));

    always_comb begin
        w_side_in.xx   = i_rot_xx;
        w_side_in.yx   = i_rot_yx;
        w_side_in.zy   = i_rot_zy;
        w_side_in.zz   = i_rot_zz;
        w_side_in.yz   = i_rot_yz;
        w_side_in.xz   = i_rot_xz;
        w_side_in.lock = w_asum < {1'b0, r_thr};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq      <= $unsigned(w_sq_xx) + $unsigned(w_sq_yx);
            r_side[0] <= w_side_in;
            for (int k = 1; k < SD; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // square root chain
    assign w_sq[0] = '{rem: r_sq, root: '0};

    for (genvar g = 0; g < SQS; g++) begin : g_sqrt
        rme_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (rme_pkg::SQ_STG_W'(g)),
            .i_data  (w_sq[g]),
            .o_data  (w_sq[g+1])
        );
    end

    // rot_zx rides with the square root chain
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zx[0] <= i_rot_zx;
            for (int k = 1; k <= SQS; k++) begin
                r_zx[k] <= r_zx[k-1];
            end
        end
    end
    assign w_zx_d = r_zx[SQS];

    // pitch pre-rotation
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc <= rme_pkg::cordic_pre(-rme_pkg::PRE_W'(w_zx_d),
                                        $signed({1'b0, w_sq[SQS].root[16:0]}));
        end
    end

    // pitch cordic chain
    assign w_pc[0] = r_pc;

    for (genvar g = 0; g < CS; g++) begin : g_pitch
        rme_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (rme_pkg::STG_W'(g)),
            .i_data  (w_pc[g]),
            .o_data  (w_pc[g+1])
        );
    end

    // pitch rounding and clamp
    assign w_pitch_s = rme_pkg::sat(rme_pkg::cordic_post(w_pc[CS]), rme_pkg::ANGLE_MAX_HALF);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pitch <= w_pitch_s[14:0];
        end
    end

    // roll and yaw pre-rotation, yaw operands picked by lock and pitch sign
    assign w_side_q = r_side[SD-1];

    always_comb begin
        if (!w_side_q.lock) begin
            n_yc = rme_pkg::cordic_pre(rme_pkg::PRE_W'(w_side_q.yx),
                                       rme_pkg::PRE_W'(w_side_q.xx));
        end else if (r_pitch > 0) begin
            n_yc = rme_pkg::cordic_pre(rme_pkg::PRE_W'(w_side_q.yz),
                                       rme_pkg::PRE_W'(w_side_q.xz));
        end else begin
            n_yc = rme_pkg::cordic_pre(-rme_pkg::PRE_W'(w_side_q.yz),
                                       -rme_pkg::PRE_W'(w_side_q.xz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rc          <= rme_pkg::cordic_pre(rme_pkg::PRE_W'(w_side_q.zy),
                                                 rme_pkg::PRE_W'(w_side_q.zz));
            r_yc          <= n_yc;
            r_pl[0].pitch <= r_pitch;
            r_pl[0].lock  <= w_side_q.lock;
            for (int k = 1; k <= CS; k++) begin
                r_pl[k] <= r_pl[k-1];
            end
        end
    end

    // roll and yaw cordic chains
    assign w_rc[0] = r_rc;
    assign w_yc[0] = r_yc;

    for (genvar g = 0; g < CS; g++) begin : g_ry
        rme_cordic_cell u_roll (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (rme_pkg::STG_W'(g)),
            .i_data  (w_rc[g]),
            .o_data  (w_rc[g+1])
        );
        rme_cordic_cell u_yaw (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_stage (rme_pkg::STG_W'(g)),
            .i_data  (w_yc[g]),
            .o_data  (w_yc[g+1])
        );
    end

    // output register
    assign w_roll_s = rme_pkg::sat(rme_pkg::cordic_post(w_rc[CS]), rme_pkg::ANGLE_MAX_PI);
    assign w_yaw_s  = rme_pkg::sat(rme_pkg::cordic_post(w_yc[CS]), rme_pkg::ANGLE_MAX_PI);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll    <= r_pl[CS].lock ? 16'sd0 : w_roll_s[15:0];
            r_yaw     <= w_yaw_s[15:0];
            r_pitch_o <= r_pl[CS].pitch;
            r_lock    <= r_pl[CS].lock;
        end
    end

    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch_o;
    assign o_yaw_angle   = r_yaw;
    assign o_gimbal_lock = r_lock;

    // roll is cleared whenever the lock branch was taken
    a_lock_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gimbal_lock |-> o_roll_angle == 16'sd0)
        else $error("roll not zero under gimbal lock");

    // pitch stays within half pi
    a_pitch_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= 15'sd12868) && (o_pitch_angle >= -15'sd12868))
        else $error("pitch out of range");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // no output beat in the first cycle after reset
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("valid output right after reset");

endmodule

@@ tb/sv/rotation_matrix_to_euler_tb.sv @@
// testbench for the zyx euler angle block: directed and random matrices checked against a bit-exact predictor
`timescale 1ns / 100ps

module rotation_matrix_to_euler_tb;

    localparam int NUM_RANDOM  = 1850;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = rme_pkg::LATENCY + 20;
    localparam longint PI_FX   = 64'sd3373259426;

    typedef struct {
        logic signed [15:0] xx, yx, zx, zy, zz, yz, xz;
    } matrix_t;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               lock;
    } angles_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [15:0]        i_cfg_wr_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_rot_xx, i_rot_yx, i_rot_zx, i_rot_zy, i_rot_zz, i_rot_yz, i_rot_xz;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_roll_angle;
    logic signed [14:0] o_pitch_angle;
    logic signed [15:0] o_yaw_angle;
    logic               o_gimbal_lock;

    matrix_t matrix_q[$];
    angles_t angles_q[$];
    longint  threshold_val;
    int      mismatch_cnt;
    longint  cycle_cnt;
    int      tx_gap;
    int      rx_gap;

    rotation_matrix_to_euler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_rot_xx(i_rot_xx), .i_rot_yx(i_rot_yx), .i_rot_zx(i_rot_zx),
        .i_rot_zy(i_rot_zy), .i_rot_zz(i_rot_zz), .i_rot_yz(i_rot_yz),
        .i_rot_xz(i_rot_xz),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_roll_angle(o_roll_angle), .o_pitch_angle(o_pitch_angle),
        .o_yaw_angle(o_yaw_angle), .o_gimbal_lock(o_gimbal_lock)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // floor of the square root
    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // vectoring cordic arctangent, q2.13 rounded half away from zero
    function automatic longint atan2_q213(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        longint ax;
        longint mag;
        if (x == 0 && y == 0) return 0;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_FX : -PI_FX;
            x = -x;
            y = -y;
        end
        x = x * 16384;
        y = y * 16384;
        for (int i = 0; i < rme_pkg::CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(rme_pkg::atan_q30(5'(i)));
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(rme_pkg::atan_q30(5'(i)));
            end
        end
        ax = (z < 0) ? -z : z;
        mag = (ax + 65536) >>> 17;
        return (z < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // expected angles for one matrix under the current threshold
    function automatic angles_t predict_angles(matrix_t m);
        angles_t a;
        longint  hyp;
        longint  pitch;
        longint  roll;
        longint  yaw;
        longint  asum;
        hyp = int_sqrt(longint'(m.xx) * m.xx + longint'(m.yx) * m.yx);
        pitch = clamp(atan2_q213(-longint'(m.zx), hyp), 12868);
        asum = ((m.zy < 0) ? -longint'(m.zy) : longint'(m.zy))
             + ((m.zz < 0) ? -longint'(m.zz) : longint'(m.zz));
        a.lock = (asum < threshold_val);
        if (a.lock) begin
            roll = 0;
            if (pitch > 0) yaw = atan2_q213(m.yz, m.xz);
            else yaw = atan2_q213(-longint'(m.yz), -longint'(m.xz));
        end else begin
            roll = atan2_q213(m.zy, m.zz);
            yaw = atan2_q213(m.yx, m.xx);
        end
        a.roll = 16'(clamp(roll, 25736));
        a.pitch = 15'(pitch);
        a.yaw = 16'(clamp(yaw, 25736));
        return a;
    endfunction

    function automatic logic signed [15:0] rand_elem();
        int s;
        s = $urandom_range(0, 19);
        if (s == 0) return 16'($urandom);
        if (s < 3) begin
            case ($urandom_range(0, 4))
                0: return 16'sd16384;
                1: return -16'sd16384;
                2: return 16'sd0;
                3: return 16'sh8000;
                default: return 16'sd32767;
            endcase
        end
        if (s < 6) return 16'($signed($urandom_range(0, 40)) - 20);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t m;
        m.xx = rand_elem(); m.yx = rand_elem(); m.zx = rand_elem();
        m.zy = rand_elem(); m.zz = rand_elem(); m.yz = rand_elem();
        m.xz = rand_elem();
        // near gimbal lock: tiny third-row tail
        if ($urandom_range(0, 5) == 0) begin
            m.zy = 16'($signed($urandom_range(0, 16)) - 8);
            m.zz = 16'($signed($urandom_range(0, 16)) - 8);
        end
        return m;
    endfunction

    function automatic matrix_t mk(int xx, int yx, int zx, int zy, int zz, int yz, int xz);
        matrix_t m;
        m.xx = 16'(xx); m.yx = 16'(yx); m.zx = 16'(zx); m.zy = 16'(zy);
        m.zz = 16'(zz); m.yz = 16'(yz); m.xz = 16'(xz);
        return m;
    endfunction

    // append one matrix to the pending queue
    function automatic void add_matrix(matrix_t m);
        matrix_q.insert(matrix_q.size(), m);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) != 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // driver: presents queued matrices, holds each beat until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    i_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (matrix_q.size() > 0) begin
                    matrix_t m;
                    m = matrix_q.pop_front();
                    angles_q.insert(angles_q.size(), predict_angles(m));
                    i_rot_xx <= m.xx; i_rot_yx <= m.yx; i_rot_zx <= m.zx;
                    i_rot_zy <= m.zy; i_rot_zz <= m.zz; i_rot_yz <= m.yz;
                    i_rot_xz <= m.xz;
                    i_valid <= 1'b1;
                    tx_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output beat and paces i_ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (angles_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected output beat");
                end else begin
                    angles_t e;
                    e = angles_q.pop_front();
                    if (e.roll !== o_roll_angle || e.pitch !== o_pitch_angle ||
                        e.yaw !== o_yaw_angle || e.lock !== o_gimbal_lock) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch exp r=%0d p=%0d y=%0d l=%0d act r=%0d p=%0d y=%0d l=%0d",
                                e.roll, e.pitch, e.yaw, e.lock, o_roll_angle,
                                o_pitch_angle, o_yaw_angle, o_gimbal_lock);
                    end
                end
            end
            if (rx_gap > 0) begin
                i_ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else begin
                i_ready <= 1'b1;
                rx_gap <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // wait for everything queued to drain, then let the pipeline settle
    task automatic wait_idle();
        while (matrix_q.size() > 0 || angles_q.size() > 0 || i_valid) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(longint v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= 16'(v);
        threshold_val = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        longint thr_list[6];
        thr_list = '{0, 32768, 65535, 20, 8, 3};
        mismatch_cnt = 0;
        cycle_cnt = 0;
        threshold_val = 1;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_rot_xx, i_rot_yx, i_rot_zx, i_rot_zy, i_rot_zz, i_rot_yz, i_rot_xz} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, extremes, zero vectors, zero over negative, gimbal lock
        add_matrix(mk(16384, 0, 0, 0, 16384, 0, 0));
        add_matrix(mk(0, 0, 0, 0, 0, 0, 0));
        add_matrix(mk(-16384, 0, 0, 0, -16384, 0, -16384));
        add_matrix(mk(0, 0, -16384, 0, 0, 5000, 16384));
        add_matrix(mk(0, 0, 16384, 0, 0, -5000, -16384));
        add_matrix(mk(0, 0, 16384, 0, 0, 0, 0));
        add_matrix(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        add_matrix(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        add_matrix(mk(16384, 16384, -16384, 16384, 16384, 16384, 16384));
        add_matrix(mk(-16384, -16384, 16384, -16384, -16384, -16384, -16384));
        add_matrix(mk(0, 16384, 0, -16384, 0, 0, 0));
        add_matrix(mk(11585, 11585, 0, 11585, 11585, 0, 0));
        wait_idle();

        // directed lock cases at a wide threshold
        set_threshold(32768);
        add_matrix(mk(0, 0, -16384, 0, 0, 16384, -16384));
        add_matrix(mk(0, 0, 16384, 100, -100, -16384, 16384));
        add_matrix(mk(0, 0, 0, 0, 0, 0, -16384));
        add_matrix(mk(16384, 0, 0, 16384, 16383, 0, 0));
        wait_idle();

        // random phases across thresholds
        for (int p = 0; p < 6; p++) begin
            set_threshold(thr_list[p]);
            for (int n = 0; n < NUM_RANDOM / 6; n++) add_matrix(rand_matrix());
            wait_idle();
        end

        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ rotation_matrix_to_euler.f @@
design/rme_pkg.sv
design/rme_sqrt_cell.sv
design/rme_cordic_cell.sv
design/rotation_matrix_to_euler.sv
tb/sv/rotation_matrix_to_euler_tb.sv
